// ===== hdl/voxel_face_visibility_assert.svh =====
`ifndef VOXEL_FACE_VISIBILITY_ASSERT_SVH
`define VOXEL_FACE_VISIBILITY_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VFV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel_face_visibility check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define VFV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel_face_visibility check failed");

`endif

// ===== hdl/vfv_pkg.sv =====
package vfv_pkg;

    localparam int EDGE_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int SIDE_W  = 3;
    localparam int POS_W   = 4;
    localparam int KIND_W  = 8;
    localparam int MASK_W  = 6;
    localparam int CRD_W   = 6;
    localparam int NUM_SIDES = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_CELL  = 2'd0,
        CMD_LOAD_PLANE = 2'd1,
        CMD_QUERY      = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUERY,
        S_DONE
    } state_t;

    // what the address unit looks up
    typedef enum logic [1:0] {
        AK_CELL,
        AK_ADJ,
        AK_PLANE
    } addr_kind_t;

    typedef logic [CRD_W-1:0] crd_t;

endpackage

// ===== hdl/vfv_addr.sv =====
module vfv_addr
    import vfv_pkg::*;
#(
    parameter int EDGE = EDGE_DEF
)
(
    input  addr_kind_t                          kind,
    input  logic [SIDE_W-1:0]                   dir,
    input  crd_t                                x,
    input  crd_t                                y,
    input  crd_t                                z,
    output logic                                use_plane,
    output logic [$clog2(EDGE*EDGE*EDGE)-1:0]   chunk_addr,
    output logic [$clog2(6*EDGE*EDGE)-1:0]      plane_addr
);

    localparam int   CAW      = $clog2(EDGE*EDGE*EDGE);
    localparam int   PAW      = $clog2(6*EDGE*EDGE);
    localparam crd_t EDGE_MAX = CRD_W'(EDGE - 1);

    logic [1:0] axis;
    crd_t       c;
    logic       at_edge;
    logic       adj;
    crd_t       nx;
    crd_t       ny;
    crd_t       nz;
    crd_t       u;
    crd_t       v;
    crd_t       step_c;

    always_comb
    begin
        axis = dir[2:1];
        case (axis)
            2'd0:    c = x;
            2'd1:    c = y;
            default: c = z;
        endcase
        at_edge   = dir[0] ? (c == EDGE_MAX) : (c == '0);
        adj       = (kind == AK_ADJ);
        use_plane = (kind == AK_PLANE) || (adj && at_edge);
        step_c    = dir[0] ? CRD_W'(c + 1'b1) : CRD_W'(c - 1'b1);

        nx = (adj && axis == 2'd0) ? step_c : x;
        ny = (adj && axis == 2'd1) ? step_c : y;
        nz = (adj && axis == 2'd2) ? step_c : z;

        // in-plane coordinates
        case (axis)
            2'd0:
            begin
                u = y;
                v = z;
            end
            2'd1:
            begin
                u = x;
                v = z;
            end
            default:
            begin
                u = x;
                v = y;
            end
        endcase

        chunk_addr = CAW'(32'(nz) * 32'(EDGE*EDGE) + 32'(ny) * 32'(EDGE) + 32'(nx));
        plane_addr = PAW'(32'(dir) * 32'(EDGE*EDGE) + 32'(v) * 32'(EDGE) + 32'(u));
    end

endmodule

// ===== hdl/voxel_face_visibility.sv =====
// channel   dir  fields
// s_axis    in   tuser: cmd; tdata: side, pos_x, pos_y, pos_z, block_kind
// m_axis    out  tdata: face_mask, any_visible
// cfg       in   cfg_we / cfg_wdata: air_code
//
// loads and clear complete when accepted; a query walks the seven reads
// (center plus six neighbors) in turn through one shared address unit
// and one read port on each bit memory
// rst_n clears control state and the visible flag; the bit memories are not
// cleared and hold garbage until loaded
// the input stalls during a query and while a finished result waits on a
// full output register
module voxel_face_visibility
    import vfv_pkg::*;
#(
    parameter int EDGE = EDGE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,       // air_code
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // side, pos_x, pos_y, pos_z, block_kind, pad
    input  logic [1:0]  s_axis_tuser,    // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata     // face_mask, any_visible, pad
);

    localparam int   CAW       = $clog2(EDGE*EDGE*EDGE);
    localparam int   PAW       = $clog2(6*EDGE*EDGE);
    localparam int   CDEPTH    = EDGE*EDGE*EDGE;
    localparam int   PDEPTH    = 6*EDGE*EDGE;
    localparam crd_t EDGE_C    = CRD_W'(EDGE);
    localparam logic [2:0] LAST_STEP = 3'd7;

    state_t              state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic                flag_reg, flag_next;
    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   air_code_reg;
    logic [MASK_W-1:0]   face_mask_reg;
    logic                any_vis_reg;
    logic                load_out;

    crd_t                qx_reg, qy_reg, qz_reg;
    logic                qrng_reg;
    logic                center_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic                cdat_reg;
    logic                pdat_reg;
    logic                src_plane_reg;

    logic                cmem [CDEPTH];
    logic                pmem [PDEPTH];

    cmd_t                cmd;
    logic [SIDE_W-1:0]   side;
    crd_t                in_x, in_y, in_z;
    crd_t                pl_x, pl_y, pl_z;
    logic [KIND_W-1:0]   block_kind;
    logic                in_acc;
    logic                is_air;
    logic                in_rng;
    logic                pl_rng;
    logic                cwe, pwe;
    logic                rd_bit;
    logic [MASK_W-1:0]   final_mask;

    addr_kind_t          u_kind;
    logic [SIDE_W-1:0]   u_dir;
    crd_t                u_x, u_y, u_z;
    logic                use_plane;
    logic [CAW-1:0]      caddr;
    logic [PAW-1:0]      paddr;

    assign cmd        = cmd_t'(s_axis_tuser);
    assign side       = s_axis_tdata[2:0];
    assign in_x       = CRD_W'(s_axis_tdata[6:3]);
    assign in_y       = CRD_W'(s_axis_tdata[10:7]);
    assign in_z       = CRD_W'(s_axis_tdata[14:11]);
    assign block_kind = s_axis_tdata[22:15];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_air        = (block_kind == air_code_reg);
    assign in_rng        = (in_x < EDGE_C) && (in_y < EDGE_C) && (in_z < EDGE_C);

    // plane cell: coordinate along the side axis is ignored
    always_comb
    begin
        pl_x = in_x;
        pl_y = in_y;
        pl_z = in_z;
        case (side[2:1])
            2'd0:    pl_x = '0;
            2'd1:    pl_y = '0;
            default: pl_z = '0;
        endcase
    end

    assign pl_rng = (pl_x < EDGE_C) && (pl_y < EDGE_C) && (pl_z < EDGE_C)
                    && (side < SIDE_W'(NUM_SIDES));

    assign cwe = in_acc && (cmd == CMD_LOAD_CELL) && in_rng;
    assign pwe = in_acc && (cmd == CMD_LOAD_PLANE) && pl_rng;

    // shared address unit: load address when idle, query walk otherwise
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            u_kind = (cmd == CMD_LOAD_PLANE) ? AK_PLANE : AK_CELL;
            u_dir  = side;
            u_x    = (cmd == CMD_LOAD_PLANE) ? pl_x : in_x;
            u_y    = (cmd == CMD_LOAD_PLANE) ? pl_y : in_y;
            u_z    = (cmd == CMD_LOAD_PLANE) ? pl_z : in_z;
        end
        else
        begin
            u_kind = (step_reg == 3'd0) ? AK_CELL : AK_ADJ;
            u_dir  = 3'(step_reg - 3'd1);
            u_x    = qx_reg;
            u_y    = qy_reg;
            u_z    = qz_reg;
        end
    end

    vfv_addr #(
        .EDGE (EDGE)
    ) u_addr (
        .kind       (u_kind),
        .dir        (u_dir),
        .x          (u_x),
        .y          (u_y),
        .z          (u_z),
        .use_plane  (use_plane),
        .chunk_addr (caddr),
        .plane_addr (paddr)
    );

    always_ff @(posedge clk)
    begin
        if (cwe)
        begin
            cmem[caddr] <= is_air;
        end
        cdat_reg <= cmem[caddr];
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            pmem[paddr] <= is_air;
        end
        pdat_reg <= pmem[paddr];
    end

    assign rd_bit     = src_plane_reg ? pdat_reg : cdat_reg;
    assign final_mask = (qrng_reg && !center_reg) ? mask_reg : '0;

    always_ff @(posedge clk)
    begin
        src_plane_reg <= use_plane;
        if (in_acc && cmd == CMD_QUERY)
        begin
            qx_reg   <= in_x;
            qy_reg   <= in_y;
            qz_reg   <= in_z;
            qrng_reg <= in_rng;
        end
        // consume the read issued at the previous step
        if (state_reg == S_QUERY && step_reg != 3'd0)
        begin
            if (step_reg == 3'd1)
            begin
                center_reg <= rd_bit;
            end
            else
            begin
                mask_reg <= {rd_bit, mask_reg[MASK_W-1:1]};
            end
        end
        if (load_out)
        begin
            face_mask_reg <= final_mask;
            any_vis_reg   <= flag_reg || (final_mask != '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        flag_next  = flag_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        CMD_QUERY:
                        begin
                            state_next = S_QUERY;
                            step_next  = 3'd0;
                        end
                        CMD_CLEAR:
                        begin
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_QUERY:
            begin
                step_next = 3'(step_reg + 3'd1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (final_mask != '0)
                    begin
                        flag_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            air_code_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                air_code_reg <= cfg_wdata;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, any_vis_reg, face_mask_reg};

`include "voxel_face_visibility_assert.svh"

    `VFV_ASSERT_NXT(a_query_starts, in_acc && cmd == CMD_QUERY, state_reg == S_QUERY && step_reg == 3'd0)
    `VFV_ASSERT_NXT(a_clear_flag, in_acc && cmd == CMD_CLEAR, !flag_reg)
    `VFV_ASSERT_IMP(a_flag_covers_mask, m_axis_tvalid && m_axis_tdata[5:0] != 6'd0, m_axis_tdata[6])
    `VFV_ASSERT_NXT(a_done_drains, state_reg == S_DONE && !out_valid_reg, state_reg == S_IDLE && out_valid_reg)

endmodule
